@@ rtl/trapezoid_profile_calculator_top_macros.svh @@
// ----------------------------------------------------------------------------
// trapezoid profile calculator assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef TRAPEZOID_PROFILE_CALCULATOR_TOP_MACROS_SVH
`define TRAPEZOID_PROFILE_CALCULATOR_TOP_MACROS_SVH

// same-cycle implication
`define TPC_ASSERT_NOW(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("tpc check failed");

// next-cycle implication
`define TPC_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("tpc check failed");

`endif

@@ rtl/tpc_pkg.sv @@
// ----------------------------------------------------------------------------
// tpc_pkg
// widths, constants and shared types of the trapezoid profile calculator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpc_pkg;

    localparam int RATE_BITS        = 24;
    localparam int FACTOR_FRAC_BITS = 16;

    localparam int NOM_W  = 24;
    localparam int FAC_W  = 17;
    localparam int ACC_W  = 24;
    localparam int CNT_W  = 24;
    localparam int RATE_W = 24;
    localparam int IDX_W  = 25;
    localparam int CFG_W  = 16;

    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 104;

    localparam int PROD_W = NOM_W + FAC_W;
    localparam int SQ_W   = 2 * RATE_W;
    localparam int NUM_W  = 51;
    localparam int DEN_W  = ACC_W + 2;
    localparam int SW     = 56;
    localparam int LANES  = 3;

    localparam logic [CFG_W-1:0] MIN_RATE_RST = 16'd120;

    localparam longint RATE_CAP_L = (RATE_BITS < 24) ? ((64'd1 << RATE_BITS) - 1) : 64'hFFFFFF;
    localparam logic [RATE_W+1:0] RATE_CAP = (RATE_W + 2)'(RATE_CAP_L);
    localparam logic [PROD_W:0] ROUND_UP = (PROD_W + 1)'((64'd1 << FACTOR_FRAC_BITS) - 1);

    localparam logic signed [SW-1:0] IDX_MAX = SW'(64'sd16777215);
    localparam logic signed [SW-1:0] IDX_MIN = -SW'(64'sd16777216);

    localparam int LANE_ACC = 0;
    localparam int LANE_DEC = 1;
    localparam int LANE_MID = 2;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_lane_t;

    typedef struct packed {
        logic [NUM_W-1:0] quot;
        logic             rem_nz;
    } div_res_t;

    typedef struct packed {
        logic [RATE_W-1:0] start_rate;
        logic [RATE_W-1:0] end_rate;
        logic [CNT_W-1:0]  cnt;
        logic              accel_nz;
        logic              busy;
        logic              neg_acc;
        logic              neg_dec;
        logic              neg_mid;
    } side_t;

endpackage

@@ rtl/trapezoid_profile_calculator_top.sv @@
// path: an accepted input word passes stages s1 to s4, the divider, f1, f2 and the output register
// throughput: one segment per cycle, limited by nothing but output back-pressure
// the 51-stage divider sets the latency; a stall on m_tready freezes all stages
// reset: rst_n clears all valid bits and loads min_rate_reg with 120
// ----------------------------------------------------------------------------
// trapezoid_profile_calculator_top
// pipelined trapezoidal stepper profile: rates, ramp lengths, meeting point
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trapezoid_profile_calculator_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tpc_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // cruise rate, entry factor, exit factor, acceleration, step count, zero pad
    input  logic [tpc_pkg::IN_DATA_W-1:0]        s_tdata,
    // busy flag
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // ramp end index, decel start index, start rate, end rate, zero pad
    output logic [tpc_pkg::OUT_DATA_W-1:0]       m_tdata,
    // updated
    output logic                                 m_tuser
);
    import tpc_pkg::*;

    function automatic logic [RATE_W-1:0] fix_rate(input logic [PROD_W-1:0] p,
                                                  input logic [CFG_W-1:0] min_r);
        logic [PROD_W:0]    sum;
        logic [RATE_W+1:0]  r;
        sum = {1'b0, p} + ROUND_UP;
        r   = (RATE_W + 2)'(sum >> FACTOR_FRAC_BITS);
        if (r > RATE_CAP)
        begin
            r = RATE_CAP;
        end
        if (r < {{(RATE_W + 2 - CFG_W){1'b0}}, min_r})
        begin
            r = {{(RATE_W + 2 - CFG_W){1'b0}}, min_r};
        end
        return r[RATE_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] sat_idx(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] t;
        t = v;
        if (t > IDX_MAX)
        begin
            t = IDX_MAX;
        end
        if (t < IDX_MIN)
        begin
            t = IDX_MIN;
        end
        return t[IDX_W-1:0];
    endfunction

    logic ce;
    logic [CFG_W-1:0] min_rate_reg;

    assign ce        = ~m_tvalid | m_tready;
    assign s_tready  = ce;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_rate_reg <= MIN_RATE_RST;
        end
        else if (cfg_valid)
        begin
            min_rate_reg <= cfg_data;
        end
    end

    // input field unpack
    logic [NOM_W-1:0] in_nom;
    logic [FAC_W-1:0] in_ef;
    logic [FAC_W-1:0] in_xf;
    logic [ACC_W-1:0] in_acc;
    logic [CNT_W-1:0] in_cnt;

    assign in_nom = s_tdata[23:0];
    assign in_ef  = s_tdata[40:24];
    assign in_xf  = s_tdata[57:41];
    assign in_acc = s_tdata[81:58];
    assign in_cnt = s_tdata[105:82];

    // stage 1: products
    logic              s1_vld_reg;
    logic [PROD_W-1:0] s1_pe_reg;
    logic [PROD_W-1:0] s1_px_reg;
    logic [SQ_W-1:0]   s1_nsq_reg;
    logic [SQ_W-1:0]   s1_acnt_reg;
    logic [ACC_W-1:0]  s1_acc_reg;
    logic [CNT_W-1:0]  s1_cnt_reg;
    logic              s1_busy_reg;

    // stage 2: clamped rates
    logic              s2_vld_reg;
    logic [RATE_W-1:0] s2_start_reg;
    logic [RATE_W-1:0] s2_end_reg;
    logic [SQ_W-1:0]   s2_nsq_reg;
    logic [SQ_W-1:0]   s2_acnt_reg;
    logic [ACC_W-1:0]  s2_acc_reg;
    logic [CNT_W-1:0]  s2_cnt_reg;
    logic              s2_busy_reg;

    // stage 3: squares of rates
    logic              s3_vld_reg;
    logic [RATE_W-1:0] s3_start_reg;
    logic [RATE_W-1:0] s3_end_reg;
    logic [SQ_W-1:0]   s3_isq_reg;
    logic [SQ_W-1:0]   s3_fsq_reg;
    logic [SQ_W-1:0]   s3_nsq_reg;
    logic [SQ_W-1:0]   s3_acnt_reg;
    logic [ACC_W-1:0]  s3_acc_reg;
    logic [CNT_W-1:0]  s3_cnt_reg;
    logic              s3_busy_reg;

    // stage 4: numerator magnitudes and signs
    logic              s4_vld_reg;
    div_lane_t         s4_lane_reg [LANES];
    side_t             s4_side_reg;

    logic [SQ_W+1:0]   na_next;
    logic [SQ_W+1:0]   nd_next;
    logic [NUM_W:0]    nm_next;
    logic [SQ_W+1:0]   na_mag;
    logic [SQ_W+1:0]   nd_mag;
    logic [NUM_W:0]    nm_mag;

    always_comb
    begin
        na_next = {2'b00, s3_nsq_reg} - {2'b00, s3_isq_reg};
        nd_next = {2'b00, s3_nsq_reg} - {2'b00, s3_fsq_reg};
        nm_next = {3'b000, s3_acnt_reg, 1'b0} - {4'b0000, s3_isq_reg}
                  + {4'b0000, s3_fsq_reg};
        na_mag  = na_next[SQ_W+1] ? (~na_next + 1'b1) : na_next;
        nd_mag  = nd_next[SQ_W+1] ? (~nd_next + 1'b1) : nd_next;
        nm_mag  = nm_next[NUM_W] ? (~nm_next + 1'b1) : nm_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else if (ce)
        begin
            s1_vld_reg <= s_tvalid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s1_pe_reg    <= PROD_W'(in_nom * in_ef);
            s1_px_reg    <= PROD_W'(in_nom * in_xf);
            s1_nsq_reg   <= SQ_W'(in_nom * in_nom);
            s1_acnt_reg  <= SQ_W'(in_acc * in_cnt);
            s1_acc_reg   <= in_acc;
            s1_cnt_reg   <= in_cnt;
            s1_busy_reg  <= s_tuser;

            s2_start_reg <= fix_rate(s1_pe_reg, min_rate_reg);
            s2_end_reg   <= fix_rate(s1_px_reg, min_rate_reg);
            s2_nsq_reg   <= s1_nsq_reg;
            s2_acnt_reg  <= s1_acnt_reg;
            s2_acc_reg   <= s1_acc_reg;
            s2_cnt_reg   <= s1_cnt_reg;
            s2_busy_reg  <= s1_busy_reg;

            s3_start_reg <= s2_start_reg;
            s3_end_reg   <= s2_end_reg;
            s3_isq_reg   <= SQ_W'(s2_start_reg * s2_start_reg);
            s3_fsq_reg   <= SQ_W'(s2_end_reg * s2_end_reg);
            s3_nsq_reg   <= s2_nsq_reg;
            s3_acnt_reg  <= s2_acnt_reg;
            s3_acc_reg   <= s2_acc_reg;
            s3_cnt_reg   <= s2_cnt_reg;
            s3_busy_reg  <= s2_busy_reg;

            s4_lane_reg[LANE_ACC].num <= NUM_W'(na_mag);
            s4_lane_reg[LANE_ACC].den <= {1'b0, s3_acc_reg, 1'b0};
            s4_lane_reg[LANE_DEC].num <= NUM_W'(nd_mag);
            s4_lane_reg[LANE_DEC].den <= {1'b0, s3_acc_reg, 1'b0};
            s4_lane_reg[LANE_MID].num <= nm_mag[NUM_W-1:0];
            s4_lane_reg[LANE_MID].den <= {s3_acc_reg, 2'b00};
            s4_side_reg.start_rate    <= s3_start_reg;
            s4_side_reg.end_rate      <= s3_end_reg;
            s4_side_reg.cnt           <= s3_cnt_reg;
            s4_side_reg.accel_nz      <= |s3_acc_reg;
            s4_side_reg.busy          <= s3_busy_reg;
            s4_side_reg.neg_acc       <= na_next[SQ_W+1];
            s4_side_reg.neg_dec       <= nd_next[SQ_W+1];
            s4_side_reg.neg_mid       <= nm_next[NUM_W];
        end
    end

    // divider
    logic      dv_vld;
    div_res_t  dv_res [LANES];
    side_t     dv_side;

    tpc_divider u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (s4_vld_reg),
        .in_lane   (s4_lane_reg),
        .in_side   (s4_side_reg),
        .out_valid (dv_vld),
        .out_res   (dv_res),
        .out_side  (dv_side)
    );

    // f1: signed ramp lengths with rounding
    logic                 f1_vld_reg;
    logic signed [SW-1:0] f1_acc_reg;
    logic signed [SW-1:0] f1_dec_reg;
    logic signed [SW-1:0] f1_mid_reg;
    side_t                f1_side_reg;

    logic signed [SW-1:0] qa;
    logic signed [SW-1:0] qd;
    logic signed [SW-1:0] qm;
    logic signed [SW-1:0] acc_next;
    logic signed [SW-1:0] dec_next;
    logic signed [SW-1:0] mid_next;

    always_comb
    begin
        qa = {{(SW - NUM_W){1'b0}}, dv_res[LANE_ACC].quot};
        qd = {{(SW - NUM_W){1'b0}}, dv_res[LANE_DEC].quot};
        qm = {{(SW - NUM_W){1'b0}}, dv_res[LANE_MID].quot};
        acc_next = dv_side.neg_acc ? -qa : qa + SW'(dv_res[LANE_ACC].rem_nz);
        dec_next = dv_side.neg_dec ? -(qd + SW'(dv_res[LANE_DEC].rem_nz)) : qd;
        mid_next = dv_side.neg_mid ? -qm : qm + SW'(dv_res[LANE_MID].rem_nz);
        if (!dv_side.accel_nz)
        begin
            acc_next = '0;
            dec_next = '0;
        end
    end

    // f2: plateau test, after index, clamped meeting point
    logic                 f2_vld_reg;
    logic signed [SW-1:0] f2_until_reg;
    logic signed [SW-1:0] f2_after_reg;
    logic [CNT_W-1:0]     f2_mid_reg;
    logic                 f2_use_mid_reg;
    side_t                f2_side_reg;

    logic signed [SW-1:0] cnt_s;
    logic signed [SW-1:0] plat;
    logic [CNT_W-1:0]     mid_cl;

    always_comb
    begin
        cnt_s = {{(SW - CNT_W){1'b0}}, f1_side_reg.cnt};
        plat  = cnt_s - f1_acc_reg - f1_dec_reg;
        if (f1_mid_reg < 0)
        begin
            mid_cl = '0;
        end
        else if (f1_mid_reg > cnt_s)
        begin
            mid_cl = f1_side_reg.cnt;
        end
        else
        begin
            mid_cl = f1_mid_reg[CNT_W-1:0];
        end
    end

    // output word register
    logic                 out_vld_reg;
    logic [IDX_W-1:0]     out_until_reg;
    logic [IDX_W-1:0]     out_after_reg;
    logic [RATE_W-1:0]    out_start_reg;
    logic [RATE_W-1:0]    out_end_reg;
    logic                 out_upd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg  <= 1'b0;
            f2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (ce)
        begin
            f1_vld_reg  <= dv_vld;
            f2_vld_reg  <= f1_vld_reg;
            out_vld_reg <= f2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            f1_acc_reg     <= acc_next;
            f1_dec_reg     <= dec_next;
            f1_mid_reg     <= mid_next;
            f1_side_reg    <= dv_side;

            f2_until_reg   <= f1_acc_reg;
            f2_after_reg   <= cnt_s - f1_dec_reg;
            f2_mid_reg     <= mid_cl;
            f2_use_mid_reg <= (plat < 0) && f1_side_reg.accel_nz;
            f2_side_reg    <= f1_side_reg;

            if (f2_side_reg.busy)
            begin
                out_until_reg <= '0;
                out_after_reg <= '0;
                out_start_reg <= '0;
                out_end_reg   <= '0;
                out_upd_reg   <= 1'b0;
            end
            else
            begin
                out_until_reg <= f2_use_mid_reg ? {1'b0, f2_mid_reg} : sat_idx(f2_until_reg);
                out_after_reg <= f2_use_mid_reg ? {1'b0, f2_mid_reg} : sat_idx(f2_after_reg);
                out_start_reg <= f2_side_reg.start_rate;
                out_end_reg   <= f2_side_reg.end_rate;
                out_upd_reg   <= 1'b1;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_upd_reg;
    assign m_tdata  = {{(OUT_DATA_W - 2 * IDX_W - 2 * RATE_W){1'b0}},
                       out_end_reg, out_start_reg, out_after_reg, out_until_reg};

endmodule

@@ rtl/tpc_divider.sv @@
// ----------------------------------------------------------------------------
// tpc_divider
// three-lane restoring divider, one quotient bit per pipeline stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpc_divider
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              ce,
    input  logic                              in_valid,
    input  tpc_pkg::div_lane_t                in_lane [tpc_pkg::LANES],
    input  tpc_pkg::side_t                    in_side,
    output logic                              out_valid,
    output tpc_pkg::div_res_t                 out_res [tpc_pkg::LANES],
    output tpc_pkg::side_t                    out_side
);
    import tpc_pkg::*;

    typedef struct packed {
        logic [NUM_W-1:0] nq;
        logic [DEN_W-1:0] rem;
        logic [DEN_W-1:0] den;
    } dstate_t;

    function automatic dstate_t div_step(input dstate_t s);
        dstate_t        r;
        logic [DEN_W:0] part;
        logic [DEN_W:0] diff;
        logic           ge;
        part  = {s.rem, s.nq[NUM_W-1]};
        diff  = part - {1'b0, s.den};
        ge    = ~diff[DEN_W];
        r.den = s.den;
        r.rem = ge ? diff[DEN_W-1:0] : part[DEN_W-1:0];
        r.nq  = {s.nq[NUM_W-2:0], ge};
        return r;
    endfunction

    dstate_t stg_reg  [NUM_W][LANES];
    side_t   side_reg [NUM_W];
    logic    vld_reg  [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (ce)
            begin
                vld_reg[k] <= (k == 0) ? in_valid : vld_reg[(k == 0) ? 0 : k - 1];
            end
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    if (k == 0)
                    begin
                        stg_reg[k][l] <= div_step('{nq: in_lane[l].num, rem: '0,
                                                    den: in_lane[l].den});
                    end
                    else
                    begin
                        stg_reg[k][l] <= div_step(stg_reg[(k == 0) ? 0 : k - 1][l]);
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                side_reg[k] <= (k == 0) ? in_side : side_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            out_res[l].quot   = stg_reg[NUM_W-1][l].nq;
            out_res[l].rem_nz = |stg_reg[NUM_W-1][l].rem;
        end
    end

    assign out_valid = vld_reg[NUM_W-1];
    assign out_side  = side_reg[NUM_W-1];

endmodule

@@ rtl/tpc_checker.sv @@
// ----------------------------------------------------------------------------
// tpc_checker
// port-level checks of the profile calculator, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "trapezoid_profile_calculator_top_macros.svh"

module tpc_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [tpc_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic                            m_tuser
);

    // a held result word keeps its payload
    `TPC_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tdata, m_tuser}))
    // input side only stalls while the result word is stuck
    `TPC_ASSERT_NOW(a_stall, 1'b1, s_tready == !(m_tvalid && !m_tready))
    // a suppressed profile carries all-zero fields
    `TPC_ASSERT_NOW(a_busy_zero, m_tvalid && !m_tuser, m_tdata == '0)
    // config write is always taken
    `TPC_ASSERT_NOW(a_cfg_rdy, cfg_valid, cfg_ready)

endmodule

bind trapezoid_profile_calculator_top tpc_checker u_tpc_checker (.*);
